/* sv/nmc_pkg.sv */
// shared constants and types for the nucleotide mismatch counter
`timescale 1ns / 1ps
package nmc_pkg;

    localparam int DEF_MAX_PATTERN_LEN = 32;
    localparam int DEF_MAX_PATTERNS    = 64;

    // wide enough for any length, count or fill value up to 64
    localparam int CNT_W   = 7;
    localparam int PIDX_W  = 6;
    localparam int CODE_W  = 4;
    localparam int LOC_W   = 32;
    localparam int MISS_W  = 6;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [5:0] RST_PATTERN_LENGTH = 6'd23;
    localparam logic [6:0] RST_PATTERN_COUNT  = 7'd1;
    localparam logic [5:0] RST_MAX_MISMATCHES = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_COUNT  = 2'd1,
        CFG_MAX_MISMATCHES = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_GENOME = 1'b0,
        KIND_LOAD   = 1'b1
    } t_kind;

endpackage

/* sv/nmc_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps
module nmc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/nucleotide_mismatch_counter_unit.sv */
// top level: pattern table in ram, sliding genome window, per-pattern mismatch pipeline
//
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------------------
//  in      | i_in_valid / o_in_ready     | i_kind i_code i_load_pattern i_load_position
//  out     | o_out_valid / i_out_ready   | o_pattern_number o_location o_mismatch_count
//          |                             | o_within_limit o_last
//  cfg     | i_cfg_valid / o_cfg_ready   | i_cfg_index i_cfg_data
//
// a load request reads the pattern row, then writes it back in ST_LOAD; a genome
// request that fills no window goes straight back to idle, otherwise it passes ST_ALIGN
// and then reads one pattern row per cycle while the output can take results, through
// the single read port of the pattern ram.
// reset is synchronous: registers go to defaults, window and counters clear;
// the pattern table is not cleared. a stalled output freezes the whole
// read/count pipeline in place.
`timescale 1ns / 1ps
module nucleotide_mismatch_counter_unit #(
    parameter int MAX_PATTERN_LEN = nmc_pkg::DEF_MAX_PATTERN_LEN,
    parameter int MAX_PATTERNS    = nmc_pkg::DEF_MAX_PATTERNS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [nmc_pkg::CODE_W-1:0]    i_code,
    input  logic [5:0]                    i_load_pattern,
    input  logic [4:0]                    i_load_position,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [5:0]                    o_pattern_number,
    output logic [nmc_pkg::LOC_W-1:0]     o_location,
    output logic [nmc_pkg::MISS_W-1:0]    o_mismatch_count,
    output logic                          o_within_limit,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nmc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W  = nmc_pkg::CNT_W;
    localparam int CODE_W = nmc_pkg::CODE_W;
    localparam int ROW_W  = CODE_W * MAX_PATTERN_LEN;
    localparam int PAT_AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int WIN_AW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int NG     = (MAX_PATTERN_LEN + 7) / 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_RUN,
        ST_LOAD
    } t_state;

    t_state r_state;

    // configuration
    logic [5:0]       r_plen;
    logic [6:0]       r_pcnt;
    logic [5:0]       r_max_mis;

    // window and counters
    logic [CODE_W-1:0] r_win [MAX_PATTERN_LEN];
    logic [CNT_W-1:0]  r_fill;
    logic [nmc_pkg::LOC_W-1:0] r_seen;

    // per genome request
    logic [CODE_W-1:0] r_aligned [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] r_kmask;
    logic [nmc_pkg::LOC_W-1:0] r_start;
    logic [CNT_W-1:0]  r_cnt;
    logic [nmc_pkg::PIDX_W-1:0] r_pidx;

    // load request
    logic [PAT_AW-1:0] r_ld_addr;
    logic [4:0]        r_ld_pos;
    logic [CODE_W-1:0] r_ld_code;

    // pipeline
    logic              r_v1;
    logic [5:0]        r_p1;
    logic              r_last1;
    logic              r_v2;
    logic [5:0]        r_p2;
    logic              r_last2;
    logic [3:0]        r_grp [NG];

    logic              r_out_valid;
    logic [5:0]        r_out_pnum;
    logic [nmc_pkg::LOC_W-1:0] r_out_loc;
    logic [nmc_pkg::MISS_W-1:0] r_out_miss;
    logic              r_out_within;
    logic              r_out_last;

    // combinational
    logic              w_adv;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_load_ok;
    logic              w_issue;
    logic              w_issue_last;
    logic [CNT_W-1:0]  w_len;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  n_fill;
    logic [nmc_pkg::LOC_W-1:0] n_seen;
    logic [CODE_W-1:0] n_aligned [MAX_PATTERN_LEN];
    logic [MAX_PATTERN_LEN-1:0] n_kmask;
    logic [ROW_W-1:0]  w_rdata;
    logic [ROW_W-1:0]  w_row_new;
    logic              w_re;
    logic              w_we;
    logic [PAT_AW-1:0] w_raddr;
    logic [NG*8-1:0]   w_miss_vec;
    logic [3:0]        n_grp [NG];
    logic [CNT_W-1:0]  w_sum;
    logic [nmc_pkg::MISS_W-1:0] w_miss_sat;

    // the pipeline moves whenever the output register can take a result
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_in_ready = (r_state == ST_IDLE) && !r_v1 && !r_v2;
    assign w_accept   = i_in_valid && w_in_ready;
    assign w_load_ok  = ({1'b0, i_load_pattern} < CNT_W'(MAX_PATTERNS))
                     && ({2'b0, i_load_position} < CNT_W'(MAX_PATTERN_LEN));
    assign w_issue      = (r_state == ST_RUN) && w_adv;
    assign w_issue_last = (CNT_W'(r_pidx) + CNT_W'(1)) == r_cnt;

    // clamped length and count
    always_comb begin
        if (r_plen == 6'd0) begin
            w_len = CNT_W'(1);
        end else if (CNT_W'(r_plen) > CNT_W'(MAX_PATTERN_LEN)) begin
            w_len = CNT_W'(MAX_PATTERN_LEN);
        end else begin
            w_len = CNT_W'(r_plen);
        end
        if (r_pcnt == 7'd0) begin
            w_cnt = CNT_W'(1);
        end else if (r_pcnt > CNT_W'(MAX_PATTERNS)) begin
            w_cnt = CNT_W'(MAX_PATTERNS);
        end else begin
            w_cnt = r_pcnt;
        end
    end

    assign n_fill = (r_fill < CNT_W'(MAX_PATTERN_LEN)) ? r_fill + CNT_W'(1) : r_fill;
    assign n_seen = r_seen + 32'd1;

    // pattern position k lines up with window entry len-1-k (entry 0 newest)
    always_comb begin
        logic [CNT_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            idx = w_len - CNT_W'(1) - CNT_W'(k);
            if (CNT_W'(k) < w_len) begin
                n_aligned[k] = r_win[idx[WIN_AW-1:0]];
                n_kmask[k]   = 1'b1;
            end else begin
                n_aligned[k] = '0;
                n_kmask[k]   = 1'b0;
            end
        end
    end

    // pattern table ram, one pattern per row
    assign w_re    = w_issue || (w_accept && (i_kind == nmc_pkg::KIND_LOAD) && w_load_ok);
    assign w_raddr = (r_state == ST_RUN) ? r_pidx[PAT_AW-1:0] : i_load_pattern[PAT_AW-1:0];
    assign w_we    = (r_state == ST_LOAD);

    always_comb begin
        w_row_new = w_rdata;
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            if (CNT_W'(k) == CNT_W'(r_ld_pos)) begin
                w_row_new[k*CODE_W +: CODE_W] = r_ld_code;
            end
        end
    end

    nmc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_PATTERNS)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ld_addr),
        .i_wdata (w_row_new),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // stage 1: mismatch bits and counts per group of eight positions
    always_comb begin
        w_miss_vec = '0;
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            w_miss_vec[k] = r_kmask[k]
                         && ((r_aligned[k] & w_rdata[k*CODE_W +: CODE_W]) == '0);
        end
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                n_grp[g] = n_grp[g] + 4'(w_miss_vec[g*8 + b]);
            end
        end
    end

    // stage 2: total and threshold
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NG; g++) begin
            w_sum = w_sum + CNT_W'(r_grp[g]);
        end
        w_miss_sat = (w_sum > CNT_W'(63)) ? 6'd63 : w_sum[nmc_pkg::MISS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_plen      <= nmc_pkg::RST_PATTERN_LENGTH;
            r_pcnt      <= nmc_pkg::RST_PATTERN_COUNT;
            r_max_mis   <= nmc_pkg::RST_MAX_MISMATCHES;
            r_fill      <= '0;
            r_seen      <= '0;
            r_pidx      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    nmc_pkg::CFG_PATTERN_LENGTH: r_plen    <= i_cfg_data[5:0];
                    nmc_pkg::CFG_PATTERN_COUNT:  r_pcnt    <= i_cfg_data;
                    nmc_pkg::CFG_MAX_MISMATCHES: r_max_mis <= i_cfg_data[5:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_kind == nmc_pkg::KIND_LOAD) begin
                            r_ld_addr <= i_load_pattern[PAT_AW-1:0];
                            r_ld_pos  <= i_load_position;
                            r_ld_code <= i_code;
                            if (w_load_ok) begin
                                r_state <= ST_LOAD;
                            end
                        end else begin
                            r_win[0] <= i_code;
                            for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
                                r_win[i] <= r_win[i-1];
                            end
                            r_fill <= n_fill;
                            r_seen <= n_seen;
                            if (n_fill >= w_len) begin
                                r_state <= ST_ALIGN;
                            end
                        end
                    end
                end
                ST_ALIGN: begin
                    r_aligned <= n_aligned;
                    r_kmask   <= n_kmask;
                    r_start   <= r_seen - nmc_pkg::LOC_W'(w_len);
                    r_cnt     <= w_cnt;
                    r_pidx    <= '0;
                    r_state   <= ST_RUN;
                end
                ST_RUN: begin
                    if (w_issue) begin
                        if (w_issue_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_pidx <= r_pidx + 1'b1;
                        end
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_adv) begin
                r_v1        <= w_issue;
                r_p1        <= 6'(r_pidx);
                r_last1     <= w_issue_last;
                r_v2        <= r_v1;
                r_p2        <= r_p1;
                r_last2     <= r_last1;
                r_grp       <= n_grp;
                r_out_valid <= r_v2;
                if (r_v2) begin
                    r_out_pnum   <= r_p2;
                    r_out_loc    <= r_start;
                    r_out_miss   <= w_miss_sat;
                    r_out_within <= (w_miss_sat <= r_max_mis);
                    r_out_last   <= r_last2;
                end
            end
        end
    end

    assign o_in_ready       = w_in_ready;
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_pattern_number = r_out_pnum;
    assign o_location       = r_out_loc;
    assign o_mismatch_count = r_out_miss;
    assign o_within_limit   = r_out_within;
    assign o_last           = r_out_last;

endmodule

/* tb/sv/nmc_result_checker.sv */
// result checker: mirrors the mismatch counter state and compares every output result
`timescale 1ns / 1ps
module nmc_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_kind,
    input  logic [nmc_pkg::CODE_W-1:0]    i_code,
    input  logic [5:0]                    i_load_pattern,
    input  logic [4:0]                    i_load_position,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [5:0]                    i_pattern_number,
    input  logic [nmc_pkg::LOC_W-1:0]     i_location,
    input  logic [nmc_pkg::MISS_W-1:0]    i_mismatch_count,
    input  logic                          i_within_limit,
    input  logic                          i_last,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [nmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nmc_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results_checked
);

    localparam int CODE_W     = nmc_pkg::CODE_W;
    localparam int LOC_W      = nmc_pkg::LOC_W;
    localparam int MISS_W     = nmc_pkg::MISS_W;
    localparam int WIN_DEPTH  = nmc_pkg::DEF_MAX_PATTERN_LEN;
    localparam int ROWS       = nmc_pkg::DEF_MAX_PATTERNS;

    typedef struct packed {
        logic [5:0]        pattern_number;
        logic [LOC_W-1:0]  location;
        logic [MISS_W-1:0] mismatch_count;
        logic              within_limit;
        logic              last;
    } t_match_result;

    // window_q[0] holds the newest genome symbol
    logic [CODE_W-1:0] window_q [WIN_DEPTH];
    logic [CODE_W-1:0] pattern_rows [ROWS][WIN_DEPTH];
    logic [LOC_W-1:0]  genome_seen;
    int                window_fill;
    logic [5:0]        len_reg;
    logic [6:0]        count_reg;
    logic [5:0]        limit_reg;
    t_match_result     match_q [$];
    int                fail_total    = 0;
    int                checked_total = 0;

    function automatic int clamp_setting(input int value, input int hi);
        if (value == 0) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("[%0t] checker: %s", $time, msg);
    endtask

    task automatic predict_genome(input logic [CODE_W-1:0] sym);
        int            span;
        int            rows;
        int            miss;
        t_match_result r;
        for (int i = WIN_DEPTH - 1; i > 0; i--) window_q[i] = window_q[i-1];
        window_q[0] = sym;
        genome_seen = genome_seen + 1'b1;
        if (window_fill < WIN_DEPTH) window_fill++;
        // out of range settings saturate instead of wrapping
        span = clamp_setting(int'(len_reg), WIN_DEPTH);
        rows = clamp_setting(int'(count_reg), ROWS);
        if (window_fill < span) return;
        for (int p = 0; p < rows; p++) begin
            miss = 0;
            // oldest symbol of the window lines up with pattern position 0
            for (int k = 0; k < span; k++)
                if ((window_q[span-1-k] & pattern_rows[p][k]) == '0) miss++;
            r.pattern_number = 6'(p);
            r.location       = genome_seen - LOC_W'(span);
            r.mismatch_count = MISS_W'(miss);
            r.within_limit   = (miss <= int'(limit_reg));
            r.last           = (p == rows - 1);
            match_q = {match_q, r};
        end
    endtask

    task automatic check_result();
        t_match_result want;
        if (match_q.size() == 0) begin
            report_mismatch($sformatf("result for pattern %0d at location %0d with nothing pending",
                                      i_pattern_number, i_location));
            return;
        end
        want = match_q.pop_front();
        checked_total++;
        if (i_pattern_number !== want.pattern_number)
            report_mismatch($sformatf("pattern_number at location %0d: expected %0d got %0d",
                                      want.location, want.pattern_number, i_pattern_number));
        if (i_location !== want.location)
            report_mismatch($sformatf("location for pattern %0d: expected %0d got %0d",
                                      want.pattern_number, want.location, i_location));
        if (i_mismatch_count !== want.mismatch_count)
            report_mismatch($sformatf("mismatch_count pattern %0d location %0d: expected %0d got %0d",
                                      want.pattern_number, want.location,
                                      want.mismatch_count, i_mismatch_count));
        if (i_within_limit !== want.within_limit)
            report_mismatch($sformatf("within_limit pattern %0d location %0d: expected %0b got %0b",
                                      want.pattern_number, want.location,
                                      want.within_limit, i_within_limit));
        if (i_last !== want.last)
            report_mismatch($sformatf("last pattern %0d location %0d: expected %0b got %0b",
                                      want.pattern_number, want.location, want.last, i_last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) window_q[i] = '0;
            genome_seen = '0;
            window_fill = 0;
            len_reg     = nmc_pkg::RST_PATTERN_LENGTH;
            count_reg   = nmc_pkg::RST_PATTERN_COUNT;
            limit_reg   = nmc_pkg::RST_MAX_MISMATCHES;
            match_q.delete();
        end else begin
            // compare first so a result can never match a request of the same edge
            if (i_out_valid && i_out_ready) check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    nmc_pkg::CFG_PATTERN_LENGTH: len_reg   = i_cfg_data[5:0];
                    nmc_pkg::CFG_PATTERN_COUNT:  count_reg = i_cfg_data[6:0];
                    nmc_pkg::CFG_MAX_MISMATCHES: limit_reg = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_kind == nmc_pkg::KIND_LOAD) begin
                    if (int'(i_load_pattern) < ROWS && int'(i_load_position) < WIN_DEPTH)
                        pattern_rows[i_load_pattern][i_load_position] = i_code;
                end else begin
                    predict_genome(i_code);
                end
            end
        end
        o_pending         <= match_q.size();
        o_fail_count      <= fail_total;
        o_results_checked <= checked_total;
    end

endmodule

/* tb/sv/tb_top.sv */
// testbench top: drives requests and register writes into the mismatch counter, gives the verdict
`timescale 1ns / 1ps
module tb_top;

    localparam int CODE_W        = nmc_pkg::CODE_W;
    localparam int LOC_W         = nmc_pkg::LOC_W;
    localparam int MISS_W        = nmc_pkg::MISS_W;
    localparam int CFG_W         = nmc_pkg::CFG_W;
    localparam int CFG_IDX_W     = nmc_pkg::CFG_IDX_W;
    localparam int ROWS          = nmc_pkg::DEF_MAX_PATTERNS;
    localparam int COLS          = nmc_pkg::DEF_MAX_PATTERN_LEN;
    localparam int IDLE_PCT      = 11;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 2 * nmc_pkg::DEF_MAX_PATTERNS + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 3;
    localparam int PHASE_ITEMS   = 14;
    localparam int RAND_SPAN_MAX = 8;
    localparam int RAND_ROWS_MAX = 4;

    // nucleotide masks, ambiguity codes are unions of bases
    localparam logic [CODE_W-1:0] BASE_GAP = 4'h0;
    localparam logic [CODE_W-1:0] BASE_G   = 4'h1;
    localparam logic [CODE_W-1:0] BASE_C   = 4'h2;
    localparam logic [CODE_W-1:0] BASE_A   = 4'h4;
    localparam logic [CODE_W-1:0] BASE_T   = 4'h8;
    localparam logic [CODE_W-1:0] BASE_N   = 4'hF;
    localparam logic [CODE_W-1:0] CODE_R   = BASE_A | BASE_G;
    localparam logic [CODE_W-1:0] CODE_Y   = BASE_C | BASE_T;

    // index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_kind;
    logic [CODE_W-1:0]     i_code;
    logic [5:0]            i_load_pattern;
    logic [4:0]            i_load_position;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [5:0]            o_pattern_number;
    logic [LOC_W-1:0]      o_location;
    logic [MISS_W-1:0]     o_mismatch_count;
    logic                  o_within_limit;
    logic                  o_last;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int cycle_count  = 0;
    int genome_sent  = 0;
    int loads_sent   = 0;
    int reg_writes   = 0;
    int settings_run = 0;
    int active_rows  = 1;
    int active_span  = 1;
    bit idle_on      = 1'b1;
    bit hold_pending = 1'b0;
    bit loaded [ROWS][COLS];

    nucleotide_mismatch_counter_unit u_top (.*);

    nmc_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_code            (i_code),
        .i_load_pattern    (i_load_pattern),
        .i_load_position   (i_load_position),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_pattern_number  (o_pattern_number),
        .i_location        (o_location),
        .i_mismatch_count  (o_mismatch_count),
        .i_within_limit    (o_within_limit),
        .i_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d results outstanding",
                     CYCLE_LIMIT, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] single_bases [4] = '{BASE_A, BASE_C, BASE_G, BASE_T};
        if ($urandom_range(99) < 65) return single_bases[$urandom_range(3)];
        return CODE_W'($urandom_range(15));
    endfunction

    // valid stays high across back-to-back requests, dropped only for a gap
    task automatic push_request(input nmc_pkg::t_kind kind, input logic [CODE_W-1:0] code,
                                input logic [5:0] slot, input logic [4:0] pos);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_code          <= code;
        i_load_pattern  <= slot;
        i_load_position <= pos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (kind == nmc_pkg::KIND_LOAD) begin
            loads_sent++;
            loaded[slot][pos] = 1'b1;
        end else begin
            genome_sent++;
        end
    endtask

    task automatic post_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic set_registers(input logic [CFG_W-1:0] len_val, input logic [CFG_W-1:0] cnt_val,
                                 input logic [CFG_W-1:0] max_val);
        post_reg(nmc_pkg::CFG_PATTERN_LENGTH, len_val);
        post_reg(nmc_pkg::CFG_PATTERN_COUNT, cnt_val);
        post_reg(nmc_pkg::CFG_MAX_MISMATCHES, max_val);
        post_reg(CFG_SPARE_IDX, CFG_W'($urandom_range(127)));
        i_cfg_valid <= 1'b0;
        active_rows = (cnt_val == 0) ? 1 : ((int'(cnt_val) > ROWS) ? ROWS : int'(cnt_val));
        active_span = (len_val[5:0] == 0) ? 1
                    : ((int'(len_val[5:0]) > COLS) ? COLS : int'(len_val[5:0]));
        settings_run++;
    endtask

    // positions in use get written so no unwritten entry is ever read
    task automatic fill_rows();
        for (int p = 0; p < active_rows; p++)
            for (int k = 0; k < active_span; k++)
                if (!loaded[p][k]) push_request(nmc_pkg::KIND_LOAD, pick_code(), 6'(p), 5'(k));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // loads and short genome requests leave nothing pending but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_request();
        logic [5:0] slot;
        if ($urandom_range(99) < 75) begin
            push_request(nmc_pkg::KIND_GENOME, pick_code(), 6'($urandom_range(63)),
                         5'($urandom_range(31)));
        end else begin
            // mostly rewrite live patterns so the counts move
            slot = ($urandom_range(99) < 70) ? 6'($urandom_range(active_rows - 1))
                                             : 6'($urandom_range(63));
            push_request(nmc_pkg::KIND_LOAD, pick_code(), slot, 5'($urandom_range(31)));
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] len_val, input logic [CFG_W-1:0] cnt_val,
                             input logic [CFG_W-1:0] max_val, input int n_items,
                             input bit calm, input bit squeeze);
        settle();
        set_registers(len_val, cnt_val, max_val);
        fill_rows();
        idle_on = !calm;
        if (squeeze) hold_pending = 1'b1;
        repeat (n_items) random_request();
        idle_on = 1'b1;
    endtask

    task automatic directed_requests();
        set_registers(7'd4, 7'd3, 7'd1);
        fill_rows();
        // extremes of slot, position and code
        push_request(nmc_pkg::KIND_LOAD, BASE_N, 6'd63, 5'd31);
        push_request(nmc_pkg::KIND_LOAD, BASE_GAP, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_LOAD, CODE_Y, 6'd42, 5'd21);
        push_request(nmc_pkg::KIND_LOAD, CODE_R, 6'd21, 5'd10);
        push_request(nmc_pkg::KIND_LOAD, BASE_A, 6'd1, 5'd1);
        push_request(nmc_pkg::KIND_LOAD, BASE_T, 6'd2, 5'd3);
        // first three symbols only fill the window
        push_request(nmc_pkg::KIND_GENOME, BASE_N, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_A, 6'd63, 5'd31);
        push_request(nmc_pkg::KIND_GENOME, BASE_C, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_G, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_T, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_GAP, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_N, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, CODE_R, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, CODE_Y, 6'd0, 5'd0);
        // live pattern entry rewritten between symbols
        push_request(nmc_pkg::KIND_LOAD, BASE_N, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_C, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_A, 6'd0, 5'd0);
        push_request(nmc_pkg::KIND_GENOME, BASE_T, 6'd0, 5'd0);
    endtask

    initial begin
        int span;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_kind          = nmc_pkg::KIND_GENOME;
        i_code          = BASE_GAP;
        i_load_pattern  = '0;
        i_load_position = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = nmc_pkg::CFG_PATTERN_LENGTH;
        i_cfg_data      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_requests();
        // zero length and count act as one
        run_phase(7'd0, 7'd0, 7'd0, PHASE_ITEMS, 1'b0, 1'b0);
        // oversized count saturates to the full table, no idling, and a long output stall
        run_phase(7'd1, 7'd127, 7'd0, 24, 1'b1, 1'b1);
        // oversized length saturates
        run_phase(7'd63, 7'd1, 7'd63, 16, 1'b0, 1'b0);
        for (int n = 0; n < RANDOM_PHASES; n++) begin
            span = $urandom_range(1, RAND_SPAN_MAX);
            run_phase(7'(span), 7'($urandom_range(1, RAND_ROWS_MAX)), 7'($urandom_range(0, span)),
                      PHASE_ITEMS, 1'b0, 1'b0);
        end
        settle();

        $display("covered %0d genome symbols, %0d table loads, %0d register writes",
                 genome_sent, loads_sent, reg_writes);
        $display("over %0d settings, %0d mismatch results compared, %0d discrepancies",
                 settings_run, results_checked, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
